[design/fsc_pkg.sv]
`timescale 1ns / 1ps

package fsc_pkg;

    // Default converter width
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int CAL_W      = 10;
    localparam int WEIGHT_W   = 16;
    localparam int TICK_W     = 16;
    localparam int GRAM_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Result packing: led, relay, mode(3), weight(16), cal_error -> 22 bits, padded to bytes
    localparam int OUT_BITS = 1 + 1 + 3 + WEIGHT_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_TARGET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_WEIGHT      = 3'd4;

    // Register reset values
    localparam logic [TICK_W-1:0] LONG_PRESS_RESET      = 16'd400;
    localparam logic [TICK_W-1:0] RELEASE_TIMEOUT_RESET = 16'd400;
    localparam logic [GRAM_W-1:0] FILL_TARGET_RESET     = 15'd100;
    localparam logic [GRAM_W-1:0] RELEASE_LEVEL_RESET   = 15'd50;
    localparam logic [CAL_W-1:0]  CAL_WEIGHT_RESET      = 10'd200;

    // Calibration points after reset
    localparam int ZERO_CODE_RESET = 1241;
    localparam int FULL_CODE_RESET = 2482;

    // Saturation bounds
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sh7FFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 16'sh8000;

    // Thresholds handed to the mode controller
    typedef struct packed {
        logic [TICK_W-1:0] long_press;
        logic [TICK_W-1:0] release_timeout;
        logic [GRAM_W-1:0] fill_target;
        logic [GRAM_W-1:0] release_level;
    } ctrl_cfg_t;

endpackage

[design/filling_scale_controller_top.sv]
`timescale 1ns / 1ps

// Each tick passes the MUL, START, DIV, UPDATE and OUT states; the result then waits in a register.
// The input is not ready while a tick is in work; a new tick is taken once the last has left SEQ_OUT.
// The bit-serial divider (SAMPLE_BITS + 10 steps, one quotient bit per cycle) takes most of that work.
// A finished result waits in the output register without holding off the next tick.
// Reset (aresetn low, synchronous) clears the channels and restores registers and calibration.
module filling_scale_controller_top
    import fsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // tdata: [0] button, [SAMPLE_BITS:1] sample, zero fill above
    input  logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: [0] led, [1] relay, [4:2] mode, [20:5] weight_grams, [21] cal_error, zero fill above
    output logic [OUT_W-1:0]                       m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_addr,
    input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

    localparam int NUM_W  = SAMPLE_BITS + CAL_W;
    localparam int PROD_W = SAMPLE_BITS + CAL_W + 2;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_START,
        SEQ_DIV,
        SEQ_UPDATE,
        SEQ_OUT
    } seq_t;

    seq_t                         seq_reg;
    logic                         m_tvalid_reg;
    logic [OUT_W-1:0]             m_tdata_reg;

    // Configuration registers
    ctrl_cfg_t                    cfg_reg;
    logic [CAL_W-1:0]             cal_weight_reg;

    // Tick payload and arithmetic registers
    logic                         button_reg;
    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [SAMPLE_BITS:0]  span_reg;
    logic                         err_reg;
    logic signed [WEIGHT_W-1:0]   weight_reg;

    logic signed [SAMPLE_BITS:0]  diff_next;
    logic signed [SAMPLE_BITS:0]  span_next;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_neg;
    logic signed [SAMPLE_BITS:0]  span_neg;
    logic [NUM_W-1:0]             num_mag;
    logic [SAMPLE_BITS-1:0]       span_mag;
    logic                         quo_neg;
    logic signed [WEIGHT_W-1:0]   weight_next;
    logic                         out_load;

    logic                         div_start;
    logic [NUM_W-1:0]             div_quo;
    logic                         div_done;

    logic [SAMPLE_BITS-1:0]       zero_code;
    logic [SAMPLE_BITS-1:0]       full_code;
    logic                         led;
    logic                         relay;
    logic [2:0]                   mode;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press      <= LONG_PRESS_RESET;
            cfg_reg.release_timeout <= RELEASE_TIMEOUT_RESET;
            cfg_reg.fill_target     <= FILL_TARGET_RESET;
            cfg_reg.release_level   <= RELEASE_LEVEL_RESET;
            cal_weight_reg          <= CAL_WEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_LONG_PRESS:      cfg_reg.long_press      <= cfg_wdata;
                CFG_RELEASE_TIMEOUT: cfg_reg.release_timeout <= cfg_wdata;
                CFG_FILL_TARGET:     cfg_reg.fill_target     <= cfg_wdata[GRAM_W-1:0];
                CFG_RELEASE_LEVEL:   cfg_reg.release_level   <= cfg_wdata[GRAM_W-1:0];
                CFG_CAL_WEIGHT:      cal_weight_reg          <= cfg_wdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Offset from zero point, span and scaled numerator
    assign diff_next = $signed({1'b0, sample_reg}) - $signed({1'b0, zero_code});
    assign span_next = $signed({1'b0, full_code}) - $signed({1'b0, zero_code});
    assign prod_next = $signed({1'b0, cal_weight_reg}) * diff_next;

    // Magnitudes into the divider, sign handled outside
    assign prod_neg  = -prod_reg;
    assign span_neg  = -span_reg;
    assign num_mag   = prod_reg[PROD_W-1] ? prod_neg[NUM_W-1:0] : prod_reg[NUM_W-1:0];
    assign span_mag  = span_reg[SAMPLE_BITS] ? span_neg[SAMPLE_BITS-1:0]
                                             : span_reg[SAMPLE_BITS-1:0];
    assign quo_neg   = prod_reg[PROD_W-1] ^ span_reg[SAMPLE_BITS];
    assign div_start = (seq_reg == SEQ_START);

    fsc_div #(
        .NUM_W (NUM_W),
        .DEN_W (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (span_mag),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Apply sign and saturate to 16 bits; zero span reads as 0
    always_comb begin
        if (err_reg) begin
            weight_next = '0;
        end else if (quo_neg) begin
            weight_next = (div_quo > NUM_W'(32768)) ? WEIGHT_MIN
                                                    : -$signed(div_quo[WEIGHT_W-1:0]);
        end else begin
            weight_next = (div_quo > NUM_W'(32767)) ? WEIGHT_MAX
                                                    : $signed(div_quo[WEIGHT_W-1:0]);
        end
    end

    fsc_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (seq_reg == SEQ_UPDATE),
        .button    (button_reg),
        .sample    (sample_reg),
        .weight    (weight_reg),
        .cfg       (cfg_reg),
        .zero_code (zero_code),
        .full_code (full_code),
        .led       (led),
        .relay     (relay),
        .mode      (mode)
    );

    // Result loads when the output register is free or being emptied
    assign out_load = (seq_reg == SEQ_OUT) && (!m_tvalid_reg || m_tready);

    // Tick sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= SEQ_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (seq_reg)
                SEQ_IDLE: begin
                    if (s_tvalid) begin
                        button_reg <= s_tdata[0];
                        sample_reg <= s_tdata[SAMPLE_BITS:1];
                        seq_reg    <= SEQ_MUL;
                    end
                end
                SEQ_MUL: begin
                    prod_reg <= prod_next;
                    span_reg <= span_next;
                    err_reg  <= (span_next == '0);
                    seq_reg  <= SEQ_START;
                end
                SEQ_START: begin
                    seq_reg <= SEQ_DIV;
                end
                SEQ_DIV: begin
                    if (div_done) begin
                        weight_reg <= weight_next;
                        seq_reg    <= SEQ_UPDATE;
                    end
                end
                SEQ_UPDATE: begin
                    seq_reg <= SEQ_OUT;
                end
                SEQ_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= OUT_W'({err_reg, weight_reg, mode, relay, led});
                        seq_reg      <= SEQ_IDLE;
                    end
                end
                default: begin
                    seq_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (seq_reg == SEQ_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // One tick at a time: the input closes right after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while a tick is in work");

    // Lamp and relay are never driven together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(led && relay))
        else $error("led and relay both on");

    // A zero span always reports zero weight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[21]) |-> (m_tdata[20:5] == 16'd0))
        else $error("cal_error with nonzero weight");

endmodule

[design/fsc_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module fsc_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    // Trial subtract of the shifted partial remainder
    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            // Pulse on the last quotient step
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start) begin
                quo_reg <= dividend;
                rem_reg <= '0;
                den_reg <= divisor;
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[design/fsc_ctrl.sv]
`timescale 1ns / 1ps

// Filling / calibration mode machine, advanced once per tick
module fsc_ctrl
    import fsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       update,
    input  logic                       button,
    input  logic [SAMPLE_BITS-1:0]     sample,
    input  logic signed [WEIGHT_W-1:0] weight,
    input  ctrl_cfg_t                  cfg,
    output logic [SAMPLE_BITS-1:0]     zero_code,
    output logic [SAMPLE_BITS-1:0]     full_code,
    output logic                       led,
    output logic                       relay,
    output logic [2:0]                 mode
);

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_PRESSED   = 3'd1,
        MODE_FILLING   = 3'd2,
        MODE_RELEASING = 3'd3,
        MODE_ZERO_WAIT = 3'd4,
        MODE_ZERO_HELD = 3'd5,
        MODE_FULL_WAIT = 3'd6,
        MODE_FULL_HELD = 3'd7
    } mode_t;

    localparam logic [SAMPLE_BITS-1:0] ZERO_INIT = SAMPLE_BITS'(ZERO_CODE_RESET);
    localparam logic [SAMPLE_BITS-1:0] FULL_INIT = SAMPLE_BITS'(FULL_CODE_RESET);

    mode_t                   mode_reg;
    logic [TICK_W-1:0]       tick_count_reg;
    logic [SAMPLE_BITS-1:0]  zero_code_reg;
    logic [SAMPLE_BITS-1:0]  full_code_reg;
    logic                    led_reg;
    logic                    relay_reg;

    logic [TICK_W-1:0]       tick_inc;
    logic                    reached_target;
    logic                    drop_relay;

    // Saturating tick counter and threshold compares
    assign tick_inc       = (tick_count_reg != '1) ? tick_count_reg + 1'b1 : tick_count_reg;
    assign reached_target = (weight >= $signed({1'b0, cfg.fill_target}));
    assign drop_relay     = (weight <= $signed({1'b0, cfg.release_level}))
                         || (tick_count_reg >= cfg.release_timeout);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            tick_count_reg <= '0;
            zero_code_reg  <= ZERO_INIT;
            full_code_reg  <= FULL_INIT;
            led_reg        <= 1'b0;
            relay_reg      <= 1'b0;
        end else if (update) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (button) begin
                        mode_reg       <= MODE_PRESSED;
                        tick_count_reg <= '0;
                    end
                end
                MODE_PRESSED: begin
                    if (!button) begin
                        if (tick_count_reg < cfg.long_press) begin
                            mode_reg <= MODE_FILLING;
                            led_reg  <= 1'b1;
                        end else begin
                            mode_reg <= MODE_ZERO_WAIT;
                        end
                    end else begin
                        tick_count_reg <= tick_inc;
                    end
                end
                MODE_FILLING: begin
                    // Lamp stays on until the target is reached
                    led_reg <= !reached_target;
                    if (reached_target) begin
                        mode_reg       <= MODE_RELEASING;
                        relay_reg      <= 1'b1;
                        tick_count_reg <= '0;
                    end
                end
                MODE_RELEASING: begin
                    if (drop_relay) begin
                        relay_reg <= 1'b0;
                        mode_reg  <= MODE_IDLE;
                    end else begin
                        tick_count_reg <= tick_inc;
                    end
                end
                MODE_ZERO_WAIT: begin
                    if (button) begin
                        mode_reg      <= MODE_ZERO_HELD;
                        zero_code_reg <= sample;
                    end
                end
                MODE_ZERO_HELD: begin
                    if (!button) begin
                        mode_reg <= MODE_FULL_WAIT;
                    end
                end
                MODE_FULL_WAIT: begin
                    if (button) begin
                        mode_reg      <= MODE_FULL_HELD;
                        full_code_reg <= sample;
                    end
                end
                MODE_FULL_HELD: begin
                    if (!button) begin
                        mode_reg <= MODE_IDLE;
                    end
                end
                default: begin
                    mode_reg <= MODE_IDLE;
                end
            endcase
        end
    end

    assign zero_code = zero_code_reg;
    assign full_code = full_code_reg;
    assign led       = led_reg;
    assign relay     = relay_reg;
    assign mode      = mode_reg;

endmodule

[tb/sv/tb_filling_scale_controller_top.sv]
`timescale 1ns / 1ps

module tb_filling_scale_controller_top;
    import fsc_pkg::*;

    localparam int SMP_W       = SAMPLE_BITS_DEF;
    localparam int S_W         = ((SMP_W + 8) / 8) * 8;
    localparam int WATCHDOG    = 4000;  // cycles without any transfer
    localparam int SETTLE      = 40;    // margin after the last pending result returns
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int DIR_ROWS    = 25;
    localparam int DIR_SPLIT   = 12;    // rows before this run at reset thresholds
    localparam int RAND_ITEMS  = 60;    // per random phase

    typedef enum logic [2:0] {
        MD_IDLE      = 3'd0,
        MD_PRESSED   = 3'd1,
        MD_FILLING   = 3'd2,
        MD_RELEASING = 3'd3,
        MD_ZERO_WAIT = 3'd4,
        MD_ZERO_HELD = 3'd5,
        MD_FULL_WAIT = 3'd6,
        MD_FULL_HELD = 3'd7
    } md_t;

    // Same layout as m_tdata, led in bit 0
    typedef struct packed {
        logic                       cal_error;
        logic signed [WEIGHT_W-1:0] weight;
        md_t                        mode;
        logic                       relay;
        logic                       led;
    } scale_res_t;

    typedef struct {
        bit                         btn;
        logic [SMP_W-1:0]           smp;
        bit                         typed;
        bit                         led;
        bit                         relay;
        md_t                        mode;
        logic signed [WEIGHT_W-1:0] weight;
        bit                         err;
    } dir_row_t;

    // Directed ticks; rows with typed=1 carry the result read straight off the spec
    dir_row_t dir_tab [DIR_ROWS] = '{
        // reset calibration: zero 1241, full 2482, 200 g
        '{1'b0, 12'd1241, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd200,  1'b0},
        '{1'b0, 12'd0,    1'b1, 1'b0, 1'b0, MD_IDLE,     -16'sd200,  1'b0},
        '{1'b0, 12'd4095, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd459,  1'b0},
        '{1'b0, 12'd1,    1'b1, 1'b0, 1'b0, MD_IDLE,     -16'sd199,  1'b0},
        // short press, fill to target, drop on release level
        '{1'b1, 12'd1241, 1'b1, 1'b0, 1'b0, MD_PRESSED,   16'sd0,    1'b0},
        '{1'b1, 12'd1241, 1'b1, 1'b0, 1'b0, MD_PRESSED,   16'sd0,    1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b1, 1'b0, MD_FILLING,   16'sd200,  1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b0, 1'b1, MD_RELEASING, 16'sd200,  1'b0},
        '{1'b1, 12'd2482, 1'b1, 1'b0, 1'b1, MD_RELEASING, 16'sd200,  1'b0},
        '{1'b0, 12'd1303, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd9,    1'b0},
        '{1'b0, 12'd4095, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd459,  1'b0},
        // long press 1, timeout 1: relay drops on timeout
        '{1'b1, 12'd2482, 1'b1, 1'b0, 1'b0, MD_PRESSED,   16'sd200,  1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b1, 1'b0, MD_FILLING,   16'sd200,  1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b0, 1'b1, MD_RELEASING, 16'sd200,  1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b0, 1'b1, MD_RELEASING, 16'sd200,  1'b0},
        '{1'b0, 12'd2482, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd200,  1'b0},
        // long press into calibration, both points on one code: zero span
        '{1'b1, 12'd100,  1'b0, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b0},
        '{1'b1, 12'd100,  1'b0, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b0},
        '{1'b0, 12'd100,  1'b0, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b0},
        '{1'b1, 12'd700,  1'b0, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b0},
        '{1'b0, 12'd700,  1'b1, 1'b0, 1'b0, MD_FULL_WAIT, 16'sd0,    1'b0},
        '{1'b1, 12'd700,  1'b1, 1'b0, 1'b0, MD_FULL_HELD, 16'sd0,    1'b0},
        '{1'b0, 12'd3000, 1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b1},
        '{1'b0, 12'd0,    1'b1, 1'b0, 1'b0, MD_IDLE,      16'sd0,    1'b1}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Typed result travelling alongside the tick being offered
    bit         row_typed = 1'b0;
    scale_res_t row_res   = '0;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    bit         hold_req    = 1'b0;
    bit         hold_seen   = 1'b0;
    int         hold_left   = 0;
    int         err_count   = 0;
    int         ticks_sent  = 0;
    int         quiet_cycles = 0;
    logic [15:0] cur_long   = LONG_PRESS_RESET;

    scale_res_t pending_outputs [$];

    // Predicted controller state and thresholds
    md_t              p_mode    = MD_IDLE;
    logic [TICK_W-1:0] p_ticks  = '0;
    logic [SMP_W-1:0] p_zero    = SMP_W'(ZERO_CODE_RESET);
    logic [SMP_W-1:0] p_full    = SMP_W'(FULL_CODE_RESET);
    logic             p_led     = 1'b0;
    logic             p_relay   = 1'b0;
    logic [TICK_W-1:0] c_long    = LONG_PRESS_RESET;
    logic [TICK_W-1:0] c_timeout = RELEASE_TIMEOUT_RESET;
    logic [GRAM_W-1:0] c_fill    = FILL_TARGET_RESET;
    logic [GRAM_W-1:0] c_release = RELEASE_LEVEL_RESET;
    logic [CAL_W-1:0]  c_calw    = CAL_WEIGHT_RESET;

    filling_scale_controller_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Weight from the two-point calibration, then one step of the mode machine
    function automatic scale_res_t scale_next(input bit btn, input logic [SMP_W-1:0] smp);
        scale_res_t r;
        longint     span;
        longint     q;
        int         w;
        bit         err;
        span = longint'(p_full) - longint'(p_zero);
        if (span == 0) begin
            err = 1'b1;
            w   = 0;
        end else begin
            err = 1'b0;
            q = (longint'(c_calw) * (longint'(smp) - longint'(p_zero))) / span;
            if (q > 32767) q = 32767;
            else if (q < -32768) q = -32768;
            w = int'(q);
        end
        case (p_mode)
            MD_IDLE: begin
                if (btn) begin
                    p_mode  = MD_PRESSED;
                    p_ticks = '0;
                end
            end
            MD_PRESSED: begin
                if (!btn) begin
                    if (p_ticks < c_long) begin
                        p_mode = MD_FILLING;
                        p_led  = 1'b1;
                    end else begin
                        p_mode = MD_ZERO_WAIT;
                    end
                end else if (p_ticks != 16'hFFFF) begin
                    p_ticks = p_ticks + 1'b1;
                end
            end
            MD_FILLING: begin
                p_led = 1'b1;
                if (w >= int'(c_fill)) begin
                    p_mode  = MD_RELEASING;
                    p_led   = 1'b0;
                    p_relay = 1'b1;
                    p_ticks = '0;
                end
            end
            MD_RELEASING: begin
                if (w <= int'(c_release) || p_ticks >= c_timeout) begin
                    p_relay = 1'b0;
                    p_mode  = MD_IDLE;
                end else if (p_ticks != 16'hFFFF) begin
                    p_ticks = p_ticks + 1'b1;
                end
            end
            MD_ZERO_WAIT: begin
                if (btn) begin
                    p_mode = MD_ZERO_HELD;
                    p_zero = smp;
                end
            end
            MD_ZERO_HELD: begin
                if (!btn) p_mode = MD_FULL_WAIT;
            end
            MD_FULL_WAIT: begin
                if (btn) begin
                    p_mode = MD_FULL_HELD;
                    p_full = smp;
                end
            end
            default: begin
                if (!btn) p_mode = MD_IDLE;
            end
        endcase
        r.led       = p_led;
        r.relay     = p_relay;
        r.mode      = p_mode;
        r.weight    = WEIGHT_W'(w);
        r.cal_error = err;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (err_count < 100)
            $display("mismatch %0s: want %0d got %0d at %0t", what, want, got, $time);
        err_count++;
    endtask

    // Monitor: check results, track register writes, predict accepted ticks
    always @(posedge aclk) begin
        scale_res_t got;
        scale_res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = scale_res_t'(m_tdata[OUT_BITS-1:0]);
                if (pending_outputs.size() == 0) begin
                    report_mismatch("result with nothing pending, mode", -1, got.mode);
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.led !== want.led)
                        report_mismatch("led", want.led, got.led);
                    if (got.relay !== want.relay)
                        report_mismatch("relay", want.relay, got.relay);
                    if (got.mode !== want.mode)
                        report_mismatch("mode", want.mode, got.mode);
                    if (got.weight !== want.weight)
                        report_mismatch("weight_grams", want.weight, got.weight);
                    if (got.cal_error !== want.cal_error)
                        report_mismatch("cal_error", want.cal_error, got.cal_error);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_LONG_PRESS:      c_long    = cfg_wdata;
                    CFG_RELEASE_TIMEOUT: c_timeout = cfg_wdata;
                    CFG_FILL_TARGET:     c_fill    = cfg_wdata[GRAM_W-1:0];
                    CFG_RELEASE_LEVEL:   c_release = cfg_wdata[GRAM_W-1:0];
                    CFG_CAL_WEIGHT:      c_calw    = cfg_wdata[CAL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = scale_next(s_tdata[0], s_tdata[SMP_W:1]);
                pending_outputs.push_back(row_typed ? row_res : want);
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG);
                $display("tb_filling_scale_controller_top: errors");
                $finish;
            end
        end
    end

    // One tick transfer, with an optional random gap before it
    task automatic send_tick(input bit btn, input logic [SMP_W-1:0] smp,
                             input bit typed, input scale_res_t res);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata   <= {{(S_W - SMP_W - 1){1'b0}}, smp, btn};
        row_typed <= typed;
        row_res   <= res;
        s_tvalid  <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic send_row(input int i);
        scale_res_t res;
        res.led       = dir_tab[i].led;
        res.relay     = dir_tab[i].relay;
        res.mode      = dir_tab[i].mode;
        res.weight    = dir_tab[i].weight;
        res.cal_error = dir_tab[i].err;
        send_tick(dir_tab[i].btn, dir_tab[i].smp, dir_tab[i].typed, res);
    endtask

    // n ticks at one button level; smp < 0 picks a random code per tick
    task automatic press_run(input bit btn, input int n, input int smp);
        scale_res_t none;
        int         k;
        none = '0;
        for (k = 0; k < n; k++)
            send_tick(btn, (smp < 0) ? SMP_W'($urandom_range(0, 4095)) : SMP_W'(smp),
                      1'b0, none);
    endtask

    // Stop offering and wait for every pending result, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write all five configuration registers back to back; only called with the block idle
    task automatic set_thresholds(input logic [15:0] lp, input logic [15:0] rt,
                                  input logic [15:0] ft, input logic [15:0] rl,
                                  input logic [15:0] cw);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idx  [5];
        int                    k;
        vals = '{lp, rt, ft, rl, cw};
        idx  = '{CFG_LONG_PRESS, CFG_RELEASE_TIMEOUT, CFG_FILL_TARGET,
                 CFG_RELEASE_LEVEL, CFG_CAL_WEIGHT};
        for (k = 0; k < 5; k++) begin
            cfg_addr  <= idx[k];
            cfg_wdata <= vals[k];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_long = lp;
    endtask

    // Random operator sessions: fills, calibrations and noise
    task automatic run_random(input int n_items);
        int stop_at;
        int kind;
        int z;
        int f;
        int k;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 25 && cur_long <= 8) begin
                // long press, zero point, full point
                press_run(1'b1, cur_long + 1 + $urandom_range(0, 1), -1);
                press_run(1'b0, 1, -1);
                z = $urandom_range(0, 4095);
                press_run(1'b1, $urandom_range(1, 2), z);
                press_run(1'b0, 1, -1);
                k = $urandom_range(0, 7);
                if (k == 0) f = z;
                else if (k < 3) f = z + $urandom_range(0, 80) - 40;
                else f = $urandom_range(0, 4095);
                if (f < 0) f = 0;
                if (f > 4095) f = 4095;
                press_run(1'b1, $urandom_range(1, 2), f);
                press_run(1'b0, $urandom_range(1, 2), -1);
            end else if (kind < 80) begin
                // press of one to three ticks, then a released run on random weights (filling when the press was short)
                press_run(1'b1, $urandom_range(1, 3), -1);
                press_run(1'b0, $urandom_range(3, 14), -1);
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--)
                    press_run($urandom_range(0, 1), 1, -1);
            end
        end
    endtask

    initial begin
        int i;
        int ph;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks
        tx_idle_pct = 37;
        rx_idle_pct <= 61;
        for (i = 0; i < DIR_SPLIT; i++) send_row(i);
        settle();
        set_thresholds(16'd1, 16'd1, 16'd100, 16'd50, 16'd200);
        for (i = DIR_SPLIT; i < DIR_ROWS; i++) send_row(i);

        // Random phases, each with its own thresholds
        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: set_thresholds(16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
                1: set_thresholds(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd1000);
                2: set_thresholds(16'd3, 16'd5, 16'd150, 16'd40, 16'd200);
                3: set_thresholds(16'd2, 16'd8, 16'd20, 16'd10, 16'h0400);
                4: set_thresholds(16'd4, 16'd3, 16'h8000, 16'hFFFF, 16'hFFFF);
                default: set_thresholds(16'($urandom_range(1, 6)), 16'($urandom_range(1, 20)),
                                        16'($urandom_range(0, 300)),
                                        16'($urandom_range(0, 150)),
                                        16'($urandom_range(1, 1000)));
            endcase
            if (ph < 2) begin
                tx_idle_pct = 37;
                rx_idle_pct <= 61;
            end else if (ph < 4) begin
                tx_idle_pct = 61;
                rx_idle_pct <= 37;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (ph == 4) hold_req <= ~hold_req;
            if (ph == 2) begin
                // pause mid-phase until everything offered has come back
                run_random(RAND_ITEMS / 2);
                settle();
                run_random(RAND_ITEMS / 2);
            end else begin
                run_random(RAND_ITEMS);
            end
        end

        settle();
        if (err_count == 0)
            $display("tb_filling_scale_controller_top: clean");
        else
            $display("tb_filling_scale_controller_top: errors");
        $finish;
    end

endmodule

[filelist.f]
design/fsc_pkg.sv
design/fsc_div.sv
design/fsc_ctrl.sv
design/filling_scale_controller_top.sv
tb/sv/tb_filling_scale_controller_top.sv
